@@ hdl/uartrb_pkg.sv @@
// Shared types and constants of the UART receive and transmit ring buffers.
package uartrb_pkg;

  // Event codes carried with each input transfer.
  typedef enum logic [2:0] {
    ACT_RX_BYTE  = 3'd0,
    ACT_READ     = 3'd1,
    ACT_SEND     = 3'd2,
    ACT_TX_READY = 3'd3,
    ACT_FLUSH    = 3'd4
  } action_e;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned FILL_W = 8;

  localparam logic [ERR_W-1:0] ERR_FRAME    = 3'b001;
  localparam logic [ERR_W-1:0] ERR_OVERRUN  = 3'b010;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'b100;

  // Commands from the top level to one ring.
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctrl_t;

  // Status of one ring, valid for the current indices.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [FILL_W-1:0] fill;
  } ring_stat_t;

endpackage

@@ hdl/uartrb_ring.sv @@
// One byte ring buffer: synchronous store with registered read data and its indices.
module uartrb_ring import uartrb_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] wr_data_i,
  output ring_stat_t        stat_o,
  output logic [BYTE_W-1:0] rd_data_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_q;
  logic [IW-1:0]     w_q, w_d;
  logic [IW-1:0]     r_q, r_d;
  logic [IW-1:0]     w_next, r_next;
  logic [IW:0]       fill_sum;

  assign w_next = (w_q == LAST) ? '0 : w_q + 1'b1;
  assign r_next = (r_q == LAST) ? '0 : r_q + 1'b1;

  // Distance from read to write index plus the depth; the fill below reduces it modulo the depth.
  assign fill_sum = {1'b0, w_q} + (IW+1)'(DEPTH) - {1'b0, r_q};

  assign stat_o.full  = (w_next == r_q);
  assign stat_o.empty = (w_q == r_q);
  assign stat_o.fill  = FILL_W'((fill_sum >= (IW+1)'(DEPTH)) ?
                                fill_sum - (IW+1)'(DEPTH) : fill_sum);
  assign rd_data_o    = rd_q;

  // Both indices advance before the access: a write stores at the new write slot
  // and a read takes the byte at the new read slot.
  always_comb begin
    w_d = w_q;
    r_d = r_q;
    if (ctrl_i.flush) begin
      w_d = r_q;
    end else if (ctrl_i.push) begin
      w_d = w_next;
    end
    if (ctrl_i.pop) begin
      r_d = r_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      r_q <= '0;
    end else begin
      w_q <= w_d;
      r_q <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[w_next] <= wr_data_i;
    end
    if (ctrl_i.pop) begin
      rd_q <= mem[r_next];
    end
  end

endmodule

@@ hdl/uart_rx_tx_ring_buffers_top.sv @@
// Top level of the UART receive and transmit ring buffers with stream ports.
//
// One input transfer carries one buffer event: the action code in s_axis_tuser and
// the line byte, its frame and overrun flags and the host byte in s_axis_tdata.
// Every event yields exactly one result transfer on the master side holding the
// read byte and error bits, the no-data, send-accepted and transmit-valid flags,
// the byte for the transmitter, the transmit service flag and the receive fill.
// Each ring holds at most its depth minus one bytes.
// On acceptance of an event the indices update and the ring store is
// read or written at that edge, with the store's read data registered there.
// The result moves from the pending stage to the output register behind m_axis;
// a stalled output holds it in the pending stage. With m_axis_tready high the block
// takes one event per cycle; the registered store read and the pending stage set that.
// When the receiver stalls, the output register holds one result and the pending
// stage a second; s_axis_tready then falls until the output moves on.
// Reset clears the indices, error bits and service flag at once; store contents
// stay undefined and are never read before written, so no clearing pass runs.
module uart_rx_tx_ring_buffers_top import uartrb_pkg::*; #(
  parameter int unsigned RX_DEPTH = 8,
  parameter int unsigned TX_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] line_rx_byte, [8] line_frame_error, [9] line_overrun,
  // [17:10] host_tx_byte, [23:18] zero
  input  logic [23:0] s_axis_tdata,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_byte, [10:8] read_error, [11] no_data, [12] send_accepted,
  // [13] line_tx_valid, [21:14] line_tx_byte, [22] tx_active, [30:23] rx_fill,
  // [31] zero
  output logic [31:0] m_axis_tdata
);

  action_e           act;
  logic              in_acc;
  logic              move;

  ring_ctrl_t        rx_ctrl, tx_ctrl;
  ring_stat_t        rx_stat, tx_stat;
  logic [BYTE_W-1:0] rx_rd, tx_rd;

  logic [ERR_W-1:0]  err_q, err_d;
  logic              svc_q, svc_d;

  // Result fields decided at acceptance, waiting for the store read data.
  logic              pend_q;
  logic              p_rdok_q, p_rdok_d;
  logic [ERR_W-1:0]  p_err_q, p_err_d;
  logic              p_nodata_q, p_nodata_d;
  logic              p_acc_q, p_acc_d;
  logic              p_txv_q, p_txv_d;

  logic              out_valid_q;
  logic [31:0]       out_q;

  assign act           = action_e'(s_axis_tuser);
  assign move          = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rx_ctrl    = '0;
    tx_ctrl    = '0;
    err_d      = err_q;
    svc_d      = svc_q;
    p_rdok_d   = 1'b0;
    p_err_d    = '0;
    p_nodata_d = 1'b0;
    p_acc_d    = 1'b0;
    p_txv_d    = 1'b0;
    if (in_acc) begin
      unique case (act)
        ACT_RX_BYTE: begin
          if (rx_stat.full) begin
            err_d = ERR_OVERFLOW;
          end else begin
            rx_ctrl.push = 1'b1;
            err_d = (s_axis_tdata[8] ? ERR_FRAME : '0) | (s_axis_tdata[9] ? ERR_OVERRUN : '0);
          end
        end
        ACT_READ: begin
          if (rx_stat.empty) begin
            p_nodata_d = 1'b1;
          end else begin
            rx_ctrl.pop = 1'b1;
            p_rdok_d    = 1'b1;
            p_err_d     = err_q;
          end
        end
        ACT_SEND: begin
          if (!tx_stat.full) begin
            tx_ctrl.push = 1'b1;
            svc_d        = 1'b1;
            p_acc_d      = 1'b1;
          end
        end
        ACT_TX_READY: begin
          if (tx_stat.empty) begin
            svc_d = 1'b0;
          end else begin
            tx_ctrl.pop = 1'b1;
            p_txv_d     = 1'b1;
          end
        end
        ACT_FLUSH: begin
          rx_ctrl.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  uartrb_ring #(
    .DEPTH(RX_DEPTH)
  ) u_rx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rx_ctrl),
    .wr_data_i (s_axis_tdata[7:0]),
    .stat_o    (rx_stat),
    .rd_data_o (rx_rd)
  );

  uartrb_ring #(
    .DEPTH(TX_DEPTH)
  ) u_tx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tx_ctrl),
    .wr_data_i (s_axis_tdata[17:10]),
    .stat_o    (tx_stat),
    .rd_data_o (tx_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= '0;
      svc_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      err_q <= err_d;
      svc_q <= svc_d;
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The ring state is already updated and no newer event has been taken while a
  // result is pending, so fill and service flag read here are the post-event values.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_rdok_q   <= p_rdok_d;
      p_err_q    <= p_err_d;
      p_nodata_q <= p_nodata_d;
      p_acc_q    <= p_acc_d;
      p_txv_q    <= p_txv_d;
    end
    if (move) begin
      out_q <= {1'b0,
                rx_stat.fill,
                svc_q,
                (p_txv_q ? tx_rd : '0),
                p_txv_q,
                p_acc_q,
                p_nodata_q,
                p_err_q,
                (p_rdok_q ? rx_rd : '0)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  // The receive ring never reports more than its usable capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stat.fill <= FILL_W'(RX_DEPTH - 1))
    else $error("receive fill exceeds ring capacity");

  // A send stored in the transmit ring turns the service flag on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_ctrl.push |=> svc_q)
    else $error("service flag not set after accepted send");

  // A flush leaves the receive ring empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_ctrl.flush |=> rx_stat.empty)
    else $error("receive ring not empty after flush");

  // One event yields at most one of no-data, send-accepted and transmit-valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones(m_axis_tdata[13:11]) <= 1)
    else $error("result flags of different events combined");
`endif

endmodule
